// ----- src/rrts_pkg.sv -----
// rrts_pkg: command codes, queue membership codes, list selects and unlink
// follow-up modes shared by the round-robin task scheduler; no dependencies
package rrts_pkg;

	// command kinds carried in s_tuser
	localparam logic [2:0] K_CREATE  = 3'd0;
	localparam logic [2:0] K_REMOVE  = 3'd1;
	localparam logic [2:0] K_SUSPEND = 3'd2;
	localparam logic [2:0] K_RESUME  = 3'd3;
	localparam logic [2:0] K_ASYNC   = 3'd4;
	localparam logic [2:0] K_SCHED   = 3'd5;
	localparam logic [2:0] K_POLL    = 3'd6;

	// queue membership of a task slot
	localparam logic [1:0] M_NONE = 2'd0;
	localparam logic [1:0] M_RUN  = 2'd1;
	localparam logic [1:0] M_WAIT = 2'd2;

	// list select for head, tail and empty registers
	localparam logic L_RUN  = 1'b0;
	localparam logic L_WAIT = 1'b1;

	// follow-up after an unlink
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_PP   = 2'd1;
	localparam logic [1:0] MODE_APP  = 2'd2;

	typedef logic [2:0] kind_t;

endpackage

// ----- src/round_robin_task_scheduler.sv -----
// round_robin_task_scheduler: run and wait queues kept as doubly linked
// lists in two link memories (forward, back); depends on rrts_pkg
//
// Usage: one command item enters on the s_ group (s_tuser = kind,
// s_tdata = task slot) and exactly one result item leaves on the m_ group.
// s_tready is high while the sequencer is idle; the item is then worked
// through a sequence of link-memory read and write steps, each memory
// with one synchronous read port and one write port. Reads are only
// issued in steps that write nothing, and every write of an earlier
// step has landed before a later read, so no forwarding is needed.
// A pending drain walks the wait queue and moves each marked task to
// the head of the run queue, visiting at most MAX_TASKS entries.
// The result sits in an output register; the next item is accepted
// while it waits, and the sequencer holds its last step while the
// register is still full and m_tready is low.
// Reset empties both queues, clears all pending marks and the resume flag.
module round_robin_task_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [3:0] task_id, [7:4] zero
	input  rrts_pkg::kind_t     s_tuser,   // [2:0] kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata    // [0] next_valid, [4:1] next_task,
	                                       // [5] run_nonempty, [6] on_run, [7] ignored
);
	import rrts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = IW + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC  = 4'd1;
	localparam logic [3:0] ST_U_RD = 4'd2;
	localparam logic [3:0] ST_U_AP = 4'd3;
	localparam logic [3:0] ST_P1   = 4'd4;
	localparam logic [3:0] ST_P2   = 4'd5;
	localparam logic [3:0] ST_A1   = 4'd6;
	localparam logic [3:0] ST_A2   = 4'd7;
	localparam logic [3:0] ST_D_CK = 4'd8;
	localparam logic [3:0] ST_D_RD = 4'd9;
	localparam logic [3:0] ST_D_EV = 4'd10;
	localparam logic [3:0] ST_S_CK = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;

	logic [3:0]    state_q;
	kind_t         kind_q;
	logic [IW-1:0] t_q;
	logic          in_range_q;
	logic [IW-1:0] cur_q;
	logic          ul_q;
	logic          pp_q;
	logic [1:0]    mode_q;
	logic          drain_q;
	logic [IW-1:0] it_q;
	logic          more_q;
	logic [CW-1:0] cnt_q;
	logic          flag_q;
	logic          nv_q;
	logic [3:0]    ntask_q;
	logic          ign_q;

	logic [IW-1:0] head_q [2];
	logic [IW-1:0] tail_q [2];
	logic          empty_q [2];
	logic [1:0]    memb_q [MAX_TASKS];
	logic          pend_q [MAX_TASKS];

	logic          out_vld_q;
	logic [7:0]    out_q;

	// link memories
	logic [IW-1:0] fwd_mem [MAX_TASKS];
	logic [IW-1:0] back_mem [MAX_TASKS];
	logic [IW-1:0] fwd_rd, back_rd;
	logic          rd_en;
	logic          fwd_we, back_we;
	logic [IW-1:0] fwd_wa, fwd_wd, back_wa, back_wd;

	logic          at_head, at_tail, out_load;
	logic [IW-1:0] tid_cut;
	logic          tid_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign tid_cut  = IW'(s_tdata[3:0]);
	assign tid_ok   = (32'(s_tdata[3:0]) < MAX_TASKS);
	assign at_head  = (head_q[ul_q] == cur_q);
	assign at_tail  = (tail_q[ul_q] == cur_q);
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_tready);
	assign rd_en    = (state_q == ST_U_RD) || (state_q == ST_D_RD);

	// link write port selection per step
	always_comb begin
		fwd_we  = 1'b0;
		back_we = 1'b0;
		fwd_wa  = cur_q;
		fwd_wd  = cur_q;
		back_wa = cur_q;
		back_wd = cur_q;
		case (state_q)
			ST_U_AP: begin
				if (!empty_q[ul_q] && !at_head && !at_tail) begin
					fwd_we  = 1'b1;
					fwd_wa  = back_rd;
					fwd_wd  = fwd_rd;
					back_we = 1'b1;
					back_wa = fwd_rd;
					back_wd = back_rd;
				end
			end
			ST_P1: begin
				back_we = 1'b1;
				fwd_we  = 1'b1;
				fwd_wd  = empty_q[pp_q] ? cur_q : head_q[pp_q];
			end
			ST_P2: begin
				back_we = 1'b1;
				back_wa = head_q[pp_q];
			end
			ST_A1: begin
				fwd_we  = 1'b1;
				back_we = 1'b1;
				back_wd = empty_q[L_RUN] ? cur_q : tail_q[L_RUN];
			end
			ST_A2: begin
				fwd_we = 1'b1;
				fwd_wa = tail_q[L_RUN];
			end
			default: ;
		endcase
	end

	// forward link memory
	always_ff @(posedge clk) begin
		if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
		if (rd_en) fwd_rd <= fwd_mem[cur_q];
	end

	// back link memory
	always_ff @(posedge clk) begin
		if (back_we) back_mem[back_wa] <= back_wd;
		if (rd_en) back_rd <= back_mem[cur_q];
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= K_CREATE;
			t_q        <= '0;
			in_range_q <= 1'b0;
			cur_q      <= '0;
			ul_q       <= L_RUN;
			pp_q       <= L_RUN;
			mode_q     <= MODE_NONE;
			drain_q    <= 1'b0;
			it_q       <= '0;
			more_q     <= 1'b0;
			cnt_q      <= '0;
			flag_q     <= 1'b0;
			nv_q       <= 1'b0;
			ntask_q    <= '0;
			ign_q      <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				empty_q[i] <= 1'b1;
			end
			for (int i = 0; i < MAX_TASKS; i++) begin
				memb_q[i] <= M_NONE;
				pend_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q     <= s_tuser;
						t_q        <= tid_cut;
						cur_q      <= tid_cut;
						in_range_q <= tid_ok;
						nv_q       <= 1'b0;
						ntask_q    <= '0;
						ign_q      <= 1'b0;
						drain_q    <= 1'b0;
						mode_q     <= MODE_NONE;
						state_q    <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (!in_range_q && kind_q <= K_ASYNC) begin
						ign_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						unique case (kind_q) inside
							K_CREATE: begin
								if (memb_q[t_q] != M_NONE) begin
									ign_q   <= 1'b1;
									state_q <= ST_FIN;
								end else begin
									memb_q[t_q] <= M_RUN;
									pp_q        <= L_RUN;
									state_q     <= ST_P1;
								end
							end
							K_REMOVE: begin
								memb_q[t_q] <= M_NONE;
								if (memb_q[t_q] == M_RUN) begin
									ul_q    <= L_RUN;
									state_q <= ST_U_RD;
								end else if (memb_q[t_q] == M_WAIT) begin
									ul_q    <= L_WAIT;
									state_q <= ST_U_RD;
								end else begin
									ign_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							K_SUSPEND: begin
								if (memb_q[t_q] == M_RUN) begin
									memb_q[t_q] <= M_WAIT;
									ul_q        <= L_RUN;
									pp_q        <= L_WAIT;
									mode_q      <= MODE_PP;
									state_q     <= ST_U_RD;
								end else begin
									ign_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							K_RESUME: begin
								if (memb_q[t_q] == M_WAIT) begin
									memb_q[t_q] <= M_RUN;
									pend_q[t_q] <= 1'b0;
									ul_q        <= L_WAIT;
									pp_q        <= L_RUN;
									mode_q      <= MODE_PP;
									state_q     <= ST_U_RD;
								end else begin
									ign_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							K_ASYNC: begin
								pend_q[t_q] <= 1'b1;
								flag_q      <= 1'b1;
								state_q     <= ST_FIN;
							end
							K_SCHED, K_POLL: begin
								if (flag_q) begin
									flag_q  <= 1'b0;
									drain_q <= 1'b1;
									it_q    <= head_q[L_WAIT];
									more_q  <= !empty_q[L_WAIT];
									cnt_q   <= '0;
									state_q <= ST_D_CK;
								end else begin
									state_q <= ST_S_CK;
								end
							end
							default: begin
								ign_q   <= 1'b1;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_U_RD: state_q <= ST_U_AP;
				ST_U_AP: begin
					if (!empty_q[ul_q]) begin
						if (at_head && at_tail) empty_q[ul_q] <= 1'b1;
						else if (at_head) head_q[ul_q] <= fwd_rd;
						else if (at_tail) tail_q[ul_q] <= back_rd;
					end
					if (mode_q == MODE_PP) state_q <= ST_P1;
					else if (mode_q == MODE_APP) state_q <= ST_A1;
					else state_q <= ST_FIN;
				end
				ST_P1: begin
					if (empty_q[pp_q]) begin
						head_q[pp_q]  <= cur_q;
						tail_q[pp_q]  <= cur_q;
						empty_q[pp_q] <= 1'b0;
						state_q       <= drain_q ? ST_D_CK : ST_FIN;
					end else begin
						state_q <= ST_P2;
					end
				end
				ST_P2: begin
					head_q[pp_q] <= cur_q;
					state_q      <= drain_q ? ST_D_CK : ST_FIN;
				end
				ST_A1: begin
					if (empty_q[L_RUN]) begin
						head_q[L_RUN]  <= cur_q;
						tail_q[L_RUN]  <= cur_q;
						empty_q[L_RUN] <= 1'b0;
						state_q        <= ST_FIN;
					end else begin
						state_q <= ST_A2;
					end
				end
				ST_A2: begin
					tail_q[L_RUN] <= cur_q;
					state_q       <= ST_FIN;
				end
				ST_D_CK: begin
					if (more_q && cnt_q < CW'(MAX_TASKS)) begin
						cur_q   <= it_q;
						state_q <= ST_D_RD;
					end else begin
						drain_q <= 1'b0;
						state_q <= ST_S_CK;
					end
				end
				ST_D_RD: state_q <= ST_D_EV;
				ST_D_EV: begin
					more_q <= (cur_q != tail_q[L_WAIT]);
					it_q   <= fwd_rd;
					cnt_q  <= cnt_q + 1'b1;
					if (pend_q[cur_q]) begin
						pend_q[cur_q] <= 1'b0;
						memb_q[cur_q] <= M_RUN;
						ul_q          <= L_WAIT;
						pp_q          <= L_RUN;
						mode_q        <= MODE_PP;
						state_q       <= ST_U_AP;
					end else begin
						state_q <= ST_D_CK;
					end
				end
				ST_S_CK: begin
					if (kind_q == K_SCHED && !empty_q[L_RUN]) begin
						cur_q   <= head_q[L_RUN];
						ul_q    <= L_RUN;
						mode_q  <= MODE_APP;
						nv_q    <= 1'b1;
						ntask_q <= 4'(head_q[L_RUN]);
						state_q <= ST_U_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_q     <= {ign_q, in_range_q && (memb_q[t_q] == M_RUN),
					!empty_q[L_RUN], ntask_q, nv_q};
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// a picked task implies a non-empty run queue
	a_pick_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[5])
		else $error("picked task with empty run queue");

	// one item in flight: accept drops ready in the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while busy");

	// drain walk stays bounded
	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (cnt_q <= CW'(MAX_TASKS)))
		else $error("drain walk exceeded slot count");

	// read steps never write the link memories
	a_rd_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (!fwd_we && !back_we))
		else $error("link read overlaps a write");

endmodule
